/* src/ubh_pkg.sv */
// Shared types and constants for the uniform-bin histogram.
// Used by ubh_ctrl, ubh_datapath and uniform_bin_histogram; depends on nothing.
package ubh_pkg;

	localparam int MAX_BINS_DEF    = 64;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int COUNT_BITS_DEF  = 32;

	localparam int MAXV_BITS  = 16;
	localparam int NBINS_BITS = 7;
	localparam int INDEX_BITS = 6;
	localparam int CFG_IDX_BITS  = 1;
	localparam int CFG_DATA_BITS = 16;

	localparam logic [MAXV_BITS-1:0]  MAXV_RESET  = 16'hFFFF;
	localparam logic [NBINS_BITS-1:0] NBINS_RESET = 7'd64;

	localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_VALUE = 1'b0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_NUM_BINS  = 1'b1;

	typedef enum logic [1:0] {
		OP_COUNT = 2'd0,
		OP_DUMP  = 2'd1,
		OP_CLEAR = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WDIV,
		ST_BLOAD,
		ST_BDIV,
		ST_READ,
		ST_INCR,
		ST_DUMP
	} state_t;

	typedef struct packed {
		logic accept;
		logic load_width;
		logic load_bin;
		logic div_step;
		logic width_save;
		logic bin_save;
		logic ptr_clear;
		logic ptr_inc;
		logic dump_rd;
		logic cnt_rd;
		logic cnt_wr;
		logic clear_all;
	} cmd_t;

	typedef struct packed {
		logic width_ok;
		logic div_done;
		logic dump_last;
	} stat_t;

endpackage

/* src/ubh_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ubh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* src/ubh_datapath.sv */
// Histogram datapath: config registers, shared restoring divider, bin count RAM,
// valid bits and result registers. Depends on ubh_pkg and ubh_ram.
module ubh_datapath #(
	parameter int MAX_BINS    = ubh_pkg::MAX_BINS_DEF,
	parameter int SAMPLE_BITS = ubh_pkg::SAMPLE_BITS_DEF,
	parameter int COUNT_BITS  = ubh_pkg::COUNT_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  ubh_pkg::cmd_t                      cmd,
	output ubh_pkg::stat_t                     stat,
	input  logic [SAMPLE_BITS-1:0]             sample,
	input  logic                               cfg_we,
	input  logic [ubh_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [ubh_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	output logic                               strobe,
	output logic [ubh_pkg::INDEX_BITS-1:0]     bin_index,
	output logic [COUNT_BITS-1:0]              bin_count,
	output logic                               last
);

	localparam int BIN_BITS  = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
	localparam int DW        = (SAMPLE_BITS > ubh_pkg::MAXV_BITS + 1) ?
	                           SAMPLE_BITS : ubh_pkg::MAXV_BITS + 1;
	localparam int STEP_BITS = $clog2(DW + 1);
	localparam logic [ubh_pkg::NBINS_BITS-1:0] NB_MAX = ubh_pkg::NBINS_BITS'(MAX_BINS);

	logic [ubh_pkg::MAXV_BITS-1:0]  max_value_q;
	logic [ubh_pkg::NBINS_BITS-1:0] num_bins_q;
	logic [ubh_pkg::NBINS_BITS-1:0] nb_eff;
	logic [ubh_pkg::NBINS_BITS-1:0] nb_last;
	logic                           width_ok_q;
	logic [ubh_pkg::MAXV_BITS-1:0]  width_q;
	logic [SAMPLE_BITS-1:0]         sample_q;

	logic [DW-1:0]        acc_q;
	logic [DW-1:0]        quo_q;
	logic [DW-1:0]        dvs_q;
	logic [STEP_BITS-1:0] step_q;
	logic [DW:0]          trial;
	logic [DW-1:0]        diff;
	logic                 ge;
	logic [DW-1:0]        bin_sel;

	logic [BIN_BITS-1:0]   bin_q;
	logic [BIN_BITS-1:0]   ptr_q;
	logic [MAX_BINS-1:0]   valid_q;
	logic [BIN_BITS-1:0]   raddr;
	logic                  re;
	logic                  we;
	logic [COUNT_BITS-1:0] rdata;
	logic [COUNT_BITS-1:0] cur_count;

	logic                emit_s1;
	logic                last_s1;
	logic                valid_s1;
	logic [BIN_BITS-1:0] idx_s1;

	// num_bins of zero acts as one, above MAX_BINS acts as MAX_BINS
	always_comb begin
		if (num_bins_q == '0) begin
			nb_eff = ubh_pkg::NBINS_BITS'(1);
		end else if (num_bins_q > NB_MAX) begin
			nb_eff = NB_MAX;
		end else begin
			nb_eff = num_bins_q;
		end
		nb_last = nb_eff - ubh_pkg::NBINS_BITS'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_value_q <= ubh_pkg::MAXV_RESET;
			num_bins_q  <= ubh_pkg::NBINS_RESET;
			width_ok_q  <= 1'b0;
		end else if (cfg_we) begin
			width_ok_q <= 1'b0;
			case (cfg_index)
				ubh_pkg::CFG_MAX_VALUE: max_value_q <= cfg_data[ubh_pkg::MAXV_BITS-1:0];
				ubh_pkg::CFG_NUM_BINS:  num_bins_q  <= cfg_data[ubh_pkg::NBINS_BITS-1:0];
				default: ;
			endcase
		end else if (cmd.width_save) begin
			width_ok_q <= 1'b1;
		end
	end

	// restoring divider, one quotient bit per cycle; divide by zero gives all ones
	always_comb begin
		trial = {acc_q, quo_q[DW-1]};
		ge    = trial >= {1'b0, dvs_q};
		diff  = trial[DW-1:0] - dvs_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			sample_q <= sample;
		end
		if (cmd.load_width) begin
			acc_q  <= '0;
			quo_q  <= DW'(max_value_q) + DW'(nb_eff) - DW'(1);
			dvs_q  <= DW'(nb_eff);
			step_q <= '0;
		end else if (cmd.load_bin) begin
			acc_q  <= '0;
			quo_q  <= DW'(sample_q);
			dvs_q  <= DW'(width_q);
			step_q <= '0;
		end else if (cmd.div_step) begin
			acc_q  <= ge ? diff : trial[DW-1:0];
			quo_q  <= {quo_q[DW-2:0], ge};
			step_q <= step_q + STEP_BITS'(1);
		end
		if (cmd.width_save) begin
			width_q <= quo_q[ubh_pkg::MAXV_BITS-1:0];
		end
		if (cmd.bin_save) begin
			bin_q <= BIN_BITS'(bin_sel);
		end
	end

	assign bin_sel = (quo_q >= DW'(nb_eff)) ? DW'(nb_last) : quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
		end else if (cmd.ptr_clear) begin
			ptr_q <= '0;
		end else if (cmd.ptr_inc) begin
			ptr_q <= ptr_q + BIN_BITS'(1);
		end
	end

	// an entry without its valid bit reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.clear_all) begin
			valid_q <= '0;
		end else if (we) begin
			valid_q[bin_q] <= 1'b1;
		end
	end

	assign raddr     = cmd.dump_rd ? ptr_q : bin_q;
	assign re        = cmd.dump_rd | cmd.cnt_rd;
	assign cur_count = valid_s1 ? rdata : '0;
	assign we        = cmd.cnt_wr && (cur_count != '1);

	ubh_ram #(
		.WIDTH (COUNT_BITS),
		.DEPTH (MAX_BINS)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (bin_q),
		.wdata (cur_count + COUNT_BITS'(1)),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_s1 <= 1'b0;
			last_s1 <= 1'b0;
		end else begin
			emit_s1 <= cmd.dump_rd;
			last_s1 <= cmd.dump_rd & stat.dump_last;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			valid_s1 <= valid_q[raddr];
			idx_s1   <= raddr;
		end
	end

	assign stat.width_ok  = width_ok_q;
	assign stat.div_done  = step_q == STEP_BITS'(DW);
	assign stat.dump_last = ubh_pkg::NBINS_BITS'(ptr_q) == nb_last;

	assign strobe    = emit_s1;
	assign bin_index = ubh_pkg::INDEX_BITS'(idx_s1);
	assign bin_count = cur_count;
	assign last      = last_s1;

endmodule

/* src/ubh_ctrl.sv */
// Histogram controller: sequences width and bin division, count update and dump, and issues clear.
// Depends on ubh_pkg.
module ubh_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [1:0]     op,
	input  ubh_pkg::stat_t stat,
	output ubh_pkg::cmd_t  cmd,
	output logic           busy
);

	ubh_pkg::state_t state_q;
	ubh_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ubh_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ubh_pkg::ST_IDLE: begin
				if (start) begin
					cmd.accept = 1'b1;
					case (ubh_pkg::op_t'(op))
						ubh_pkg::OP_COUNT: begin
							if (stat.width_ok) begin
								state_d = ubh_pkg::ST_BLOAD;
							end else begin
								cmd.load_width = 1'b1;
								state_d        = ubh_pkg::ST_WDIV;
							end
						end
						ubh_pkg::OP_DUMP: begin
							cmd.ptr_clear = 1'b1;
							state_d       = ubh_pkg::ST_DUMP;
						end
						ubh_pkg::OP_CLEAR: cmd.clear_all = 1'b1;
						default: ;
					endcase
				end
			end
			ubh_pkg::ST_WDIV: begin
				if (stat.div_done) begin
					cmd.width_save = 1'b1;
					state_d        = ubh_pkg::ST_BLOAD;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			ubh_pkg::ST_BLOAD: begin
				cmd.load_bin = 1'b1;
				state_d      = ubh_pkg::ST_BDIV;
			end
			ubh_pkg::ST_BDIV: begin
				if (stat.div_done) begin
					cmd.bin_save = 1'b1;
					state_d      = ubh_pkg::ST_READ;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			ubh_pkg::ST_READ: begin
				cmd.cnt_rd = 1'b1;
				state_d    = ubh_pkg::ST_INCR;
			end
			ubh_pkg::ST_INCR: begin
				cmd.cnt_wr = 1'b1;
				state_d    = ubh_pkg::ST_IDLE;
			end
			ubh_pkg::ST_DUMP: begin
				cmd.dump_rd = 1'b1;
				if (stat.dump_last) begin
					state_d = ubh_pkg::ST_IDLE;
				end else begin
					cmd.ptr_inc = 1'b1;
				end
			end
			default: state_d = ubh_pkg::ST_IDLE;
		endcase
	end

	assign busy = state_q != ubh_pkg::ST_IDLE;

endmodule

/* src/uniform_bin_histogram.sv */
// Top level of the uniform-bin histogram: controller plus datapath.
// Depends on ubh_pkg, ubh_ctrl, ubh_datapath (and ubh_ram below it).
//
//   channel   handshake              payload
//   request   start & !busy          op, sample
//   config    cfg_valid & cfg_ready  cfg_index, cfg_data
//   result    strobe (one cycle)     bin_index, bin_count, last
//
// Count: busy while the radix-2 divider, D = max(SAMPLE_BITS, 17) bits wide, finds the
// bin width after a config write or reset, then the bin; its count is then incremented.
// Dump: one result per cycle, one per bin in use (num_bins, clamped); the first comes once
// the dump state is entered and its read registered. Clear: all valid bits dropped at once.
// Reset clears the store the same way. Results cannot be stalled; config is always ready.
module uniform_bin_histogram #(
	parameter int MAX_BINS    = ubh_pkg::MAX_BINS_DEF,
	parameter int SAMPLE_BITS = ubh_pkg::SAMPLE_BITS_DEF,
	parameter int COUNT_BITS  = ubh_pkg::COUNT_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [1:0]                         op,
	input  logic [SAMPLE_BITS-1:0]             sample,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [ubh_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [ubh_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	output logic                               strobe,
	output logic [ubh_pkg::INDEX_BITS-1:0]     bin_index,
	output logic [COUNT_BITS-1:0]              bin_count,
	output logic                               last
);

	ubh_pkg::cmd_t  cmd;
	ubh_pkg::stat_t stat;

	assign cfg_ready = 1'b1;

	ubh_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (op),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	ubh_datapath #(
		.MAX_BINS    (MAX_BINS),
		.SAMPLE_BITS (SAMPLE_BITS),
		.COUNT_BITS  (COUNT_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.sample    (sample),
		.cfg_we    (cfg_valid & cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.strobe    (strobe),
		.bin_index (bin_index),
		.bin_count (bin_count),
		.last      (last)
	);

	a_last_ends_dump: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |=> !strobe)
		else $error("result after last bin of dump");

	a_dump_in_order: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |=> strobe && (bin_index == $past(bin_index) + 6'd1))
		else $error("dump results not consecutive");

	a_count_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (op == ubh_pkg::OP_COUNT) |=> busy)
		else $error("count request did not start");

	a_mid_dump_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |-> busy)
		else $error("idle in the middle of a dump");

endmodule
